// File: sv/dvrt_pkg.sv
package dvrt_pkg;

  // Default table size.
  localparam int TABLE_DEPTH_DEF = 16;

  // Field widths fixed by the stream format.
  localparam int ADDR_W     = 32;
  localparam int PORT_W     = 16;
  localparam int LOC_W      = ADDR_W + PORT_W;
  localparam int HOPS_W     = 8;
  localparam int IFACE_W    = 2;
  localparam int STAMP_W    = 32;
  localparam int STATUS_W   = 3;
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_IDX_W  = 3;

  // Local locator registers.
  localparam int NUM_LOCAL = 4;
  localparam int LOC_IDX_W = 2;
  localparam int LOC_CNT_W = LOC_IDX_W + 1;

  typedef logic [STATUS_W-1:0] status_t;

  // Result status codes.
  localparam status_t STAT_LOCAL   = 3'd0;
  localparam status_t STAT_ADDED   = 3'd1;
  localparam status_t STAT_UPDATED = 3'd2;
  localparam status_t STAT_KEPT    = 3'd3;
  localparam status_t STAT_FULL    = 3'd4;
  localparam status_t STAT_ADVERT  = 3'd5;

  // Input command codes.
  localparam logic CMD_INGEST = 1'b0;
  localparam logic CMD_ADVERT = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_LOC0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_LOC1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_LOC2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_LOC3  = 3'd4;

  // One stored route, destination in the lowest bits.
  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [IFACE_W-1:0] iface;
    logic [LOC_W-1:0]   next_hop;
    logic [HOPS_W-1:0]  hops;
    logic [LOC_W-1:0]   dest;
  } route_entry_t;

  localparam int ENTRY_W = $bits(route_entry_t);

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOCAL,
    ST_SEARCH,
    ST_RESP,
    ST_ADV_OWN,
    ST_ADV_SCAN
  } state_t;

endpackage

// File: sv/distance_vector_route_table.sv
// Ingest beat: accept, then local-locator compares (a match goes straight to the response),
// then a scan of the table entries until a match or the end of the table, then the
// response. Advertise beat: accept, the own locator, then the entries up to the last
// valid one. One shared 48-bit comparator and the table RAM's single read port
// serialize this work; one item is in work at a time.
// Reset (synchronous, rst_n low) clears all valid bits at once and zeroes the config.
module distance_vector_route_table #(
  parameter int TABLE_DEPTH = dvrt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Ingest/advertise command stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // dest_addr, dest_port, adv_hops, neighbor_addr, neighbor_port, iface, now_time
  input  logic [dvrt_pkg::IN_DATA_W-1:0]      in_tdata,
  // cmd
  input  logic [0:0]                          in_tuser,
  // Result stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_addr, out_port, out_hops
  output logic [dvrt_pkg::OUT_DATA_W-1:0]     out_tdata,
  // status
  output logic [dvrt_pkg::STATUS_W-1:0]       out_tuser,
  output logic                                out_tlast,
  // Configuration writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dvrt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dvrt_pkg::LOC_W-1:0]          cfg_data
);

  localparam int          AW       = $clog2(TABLE_DEPTH);
  localparam int          VW       = $clog2(TABLE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

  // Sequencer and control registers.
  dvrt_pkg::state_t                   state_r, state_nxt;
  logic [dvrt_pkg::LOC_CNT_W-1:0]     li_r, li_nxt;
  logic [AW-1:0]                      j_r, j_nxt;
  logic                               free_found_r, free_found_nxt;
  logic [AW-1:0]                      free_idx_r, free_idx_nxt;
  logic [VW-1:0]                      remaining_r, remaining_nxt;
  dvrt_pkg::status_t                  status_r, status_nxt;
  logic [TABLE_DEPTH-1:0]             valid_r, valid_nxt;
  logic [VW-1:0]                      vcnt_r, vcnt_nxt;

  // Configuration registers.
  logic [dvrt_pkg::LOC_CNT_W-1:0]     local_count_r;
  logic [dvrt_pkg::LOC_W-1:0]         local_loc_r [dvrt_pkg::NUM_LOCAL];

  // Output register.
  logic                               out_tvalid_r, out_tvalid_nxt;
  logic [dvrt_pkg::OUT_DATA_W-1:0]    out_tdata_r, out_tdata_nxt;
  dvrt_pkg::status_t                  out_tuser_r, out_tuser_nxt;
  logic                               out_tlast_r, out_tlast_nxt;

  // Item payload captured on accept.
  logic                               cmd_r;
  logic [dvrt_pkg::LOC_W-1:0]         dest_r;
  logic [dvrt_pkg::HOPS_W-1:0]        hops_in_r;
  logic [dvrt_pkg::LOC_W-1:0]         nh_r;
  logic [dvrt_pkg::IFACE_W-1:0]       iface_r;
  logic [dvrt_pkg::STAMP_W-1:0]       stamp_r;

  // Table RAM.
  logic                               ram_we;
  logic [AW-1:0]                      ram_waddr;
  dvrt_pkg::route_entry_t             ram_wdata;
  dvrt_pkg::route_entry_t             rd_entry;
  logic [dvrt_pkg::ENTRY_W-1:0]       rd_bits;

  // Decode.
  logic                               in_accept;
  logic [dvrt_pkg::LOC_CNT_W-1:0]     n_local;
  logic                               loc_done;
  logic [dvrt_pkg::LOC_W-1:0]         cmp_b;
  logic                               cmp_eq;
  logic [dvrt_pkg::HOPS_W:0]          cand;
  logic [dvrt_pkg::HOPS_W-1:0]        stored;
  logic                               cur_valid;
  logic                               hit;
  logic                               better;
  logic                               scan_end;
  logic                               free_here;
  logic                               slot_free;

  assign in_tready  = (state_r == dvrt_pkg::ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  // A local count above four means all four locators.
  assign n_local  = (local_count_r > dvrt_pkg::LOC_CNT_W'(dvrt_pkg::NUM_LOCAL)) ?
                    dvrt_pkg::LOC_CNT_W'(dvrt_pkg::NUM_LOCAL) : local_count_r;
  assign loc_done = (li_r >= n_local);

  // The one comparator is shared by the local check and the table search.
  assign rd_entry = dvrt_pkg::route_entry_t'(rd_bits);
  assign cmp_b    = (state_r == dvrt_pkg::ST_LOCAL) ?
                    local_loc_r[li_r[dvrt_pkg::LOC_IDX_W-1:0]] : rd_entry.dest;
  assign cmp_eq   = (dest_r == cmp_b);

  // Candidate hop count at full width; the stored copy saturates.
  assign cand      = {1'b0, hops_in_r} + (dvrt_pkg::HOPS_W + 1)'(1);
  assign stored    = cand[dvrt_pkg::HOPS_W] ? '1 : cand[dvrt_pkg::HOPS_W-1:0];
  assign cur_valid = valid_r[j_r];
  assign hit       = cur_valid && cmp_eq;
  assign better    = (cand < {1'b0, rd_entry.hops});
  assign scan_end  = (j_r == LAST_IDX);
  assign free_here = !cur_valid && !free_found_r;
  assign slot_free = !out_tvalid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dvrt_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_tuser[0] == dvrt_pkg::CMD_ADVERT) ?
                      dvrt_pkg::ST_ADV_OWN : dvrt_pkg::ST_LOCAL;
        end
      end
      dvrt_pkg::ST_LOCAL: begin
        if (loc_done) begin
          state_nxt = dvrt_pkg::ST_SEARCH;
        end else if (cmp_eq) begin
          state_nxt = dvrt_pkg::ST_RESP;
        end
      end
      dvrt_pkg::ST_SEARCH: begin
        if (hit || scan_end) begin
          state_nxt = dvrt_pkg::ST_RESP;
        end
      end
      dvrt_pkg::ST_RESP: begin
        if (slot_free) begin
          state_nxt = dvrt_pkg::ST_IDLE;
        end
      end
      dvrt_pkg::ST_ADV_OWN: begin
        if (slot_free) begin
          state_nxt = (vcnt_r == '0) ? dvrt_pkg::ST_IDLE : dvrt_pkg::ST_ADV_SCAN;
        end
      end
      dvrt_pkg::ST_ADV_SCAN: begin
        if (cur_valid && slot_free && (remaining_r == VW'(1))) begin
          state_nxt = dvrt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dvrt_pkg::ST_IDLE;
    endcase
  end

  // Datapath control and outputs.
  always_comb begin
    li_nxt         = li_r;
    j_nxt          = j_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    remaining_nxt  = remaining_r;
    status_nxt     = status_r;
    valid_nxt      = valid_r;
    vcnt_nxt       = vcnt_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    out_tlast_nxt  = out_tlast_r;
    ram_we         = 1'b0;
    ram_waddr      = j_r;
    ram_wdata      = '{stamp: stamp_r, iface: iface_r, next_hop: nh_r,
                       hops: stored, dest: dest_r};
    case (state_r)
      dvrt_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          li_nxt         = '0;
          j_nxt          = '0;
          free_found_nxt = 1'b0;
        end
      end
      dvrt_pkg::ST_LOCAL: begin
        if (!loc_done) begin
          if (cmp_eq) begin
            status_nxt = dvrt_pkg::STAT_LOCAL;
          end else begin
            li_nxt = li_r + dvrt_pkg::LOC_CNT_W'(1);
          end
        end
      end
      dvrt_pkg::ST_SEARCH: begin
        if (hit) begin
          // Known destination: replace only on a strictly shorter path.
          if (better) begin
            ram_we     = 1'b1;
            status_nxt = dvrt_pkg::STAT_UPDATED;
          end else begin
            status_nxt = dvrt_pkg::STAT_KEPT;
          end
        end else begin
          if (free_here) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = j_r;
          end
          if (scan_end) begin
            // Unknown destination: insert at the lowest free slot.
            if (free_found_r || free_here) begin
              ram_we               = 1'b1;
              ram_waddr            = free_found_r ? free_idx_r : j_r;
              valid_nxt[ram_waddr] = 1'b1;
              vcnt_nxt             = vcnt_r + VW'(1);
              status_nxt           = dvrt_pkg::STAT_ADDED;
            end else begin
              status_nxt = dvrt_pkg::STAT_FULL;
            end
          end else begin
            j_nxt = j_r + AW'(1);
          end
        end
      end
      dvrt_pkg::ST_RESP: begin
        if (slot_free) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = status_r;
          out_tdata_nxt  = '0;
          out_tlast_nxt  = 1'b1;
        end
      end
      dvrt_pkg::ST_ADV_OWN: begin
        if (slot_free) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = dvrt_pkg::STAT_ADVERT;
          out_tdata_nxt  = {{dvrt_pkg::HOPS_W{1'b0}}, dest_r[dvrt_pkg::PORT_W-1:0],
                            dest_r[dvrt_pkg::LOC_W-1:dvrt_pkg::PORT_W]};
          out_tlast_nxt  = (vcnt_r == '0);
          remaining_nxt  = vcnt_r;
        end
      end
      dvrt_pkg::ST_ADV_SCAN: begin
        // Valid entries go out in ascending order; empty slots are skipped.
        if (cur_valid) begin
          if (slot_free) begin
            out_tvalid_nxt = 1'b1;
            out_tuser_nxt  = dvrt_pkg::STAT_ADVERT;
            out_tdata_nxt  = {rd_entry.hops, rd_entry.dest[dvrt_pkg::PORT_W-1:0],
                              rd_entry.dest[dvrt_pkg::LOC_W-1:dvrt_pkg::PORT_W]};
            out_tlast_nxt  = (remaining_r == VW'(1));
            remaining_nxt  = remaining_r - VW'(1);
            j_nxt          = j_r + AW'(1);
          end
        end else begin
          j_nxt = j_r + AW'(1);
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dvrt_pkg::ST_IDLE;
      li_r         <= '0;
      j_r          <= '0;
      free_found_r <= 1'b0;
      free_idx_r   <= '0;
      remaining_r  <= '0;
      status_r     <= dvrt_pkg::STAT_LOCAL;
      valid_r      <= '0;
      vcnt_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      li_r         <= li_nxt;
      j_r          <= j_nxt;
      free_found_r <= free_found_nxt;
      free_idx_r   <= free_idx_nxt;
      remaining_r  <= remaining_nxt;
      status_r     <= status_nxt;
      valid_r      <= valid_nxt;
      vcnt_r       <= vcnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_count_r <= '0;
      for (int i = 0; i < dvrt_pkg::NUM_LOCAL; i++) begin
        local_loc_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dvrt_pkg::CFG_LOCAL_COUNT: local_count_r  <= cfg_data[dvrt_pkg::LOC_CNT_W-1:0];
        dvrt_pkg::CFG_LOCAL_LOC0:  local_loc_r[0] <= cfg_data;
        dvrt_pkg::CFG_LOCAL_LOC1:  local_loc_r[1] <= cfg_data;
        dvrt_pkg::CFG_LOCAL_LOC2:  local_loc_r[2] <= cfg_data;
        dvrt_pkg::CFG_LOCAL_LOC3:  local_loc_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item capture. Bits from the bottom: dest_addr, dest_port, adv_hops,
  // neighbor_addr, neighbor_port, iface, now_time.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r     <= in_tuser[0];
      dest_r    <= {in_tdata[31:0], in_tdata[47:32]};
      hops_in_r <= in_tdata[55:48];
      nh_r      <= {in_tdata[87:56], in_tdata[103:88]};
      iface_r   <= in_tdata[105:104];
      stamp_r   <= in_tdata[137:106];
    end
  end

  // Route table storage, read one entry ahead of the scan index.
  dvrt_ram #(
    .WIDTH (dvrt_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (j_nxt),
    .rdata (rd_bits)
  );

  // The valid count tracks the valid bits.
  a_vcnt: assert property (@(posedge clk) disable iff (!rst_n)
    vcnt_r == VW'($countones(valid_r)))
    else $error("valid count out of step with valid bits");

  // Table writes happen only from the search.
  a_we_search: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == dvrt_pkg::ST_SEARCH) && (cmd_r == dvrt_pkg::CMD_INGEST))
    else $error("table write outside an ingest search");

  // An insert never lands on a valid slot.
  a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && !hit) |-> !valid_r[ram_waddr])
    else $error("insert overwrote a valid entry");

  // The advertisement scan always has entries left to send.
  a_scan_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dvrt_pkg::ST_ADV_SCAN) |-> (remaining_r != '0))
    else $error("advertisement scan with nothing left");

  // An ingest result is always the only and last beat.
  a_ingest_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && (out_tuser_r != dvrt_pkg::STAT_ADVERT)) |-> out_tlast_r)
    else $error("ingest result without last");

endmodule

// File: sv/dvrt_ram.sv
module dvrt_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
